// ----- rtl/lrwp_pkg.sv -----
// Shared types, constants and helper functions of the rainbow wipe pixel pipeline.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
package lrwp_pkg;

  // Matrix geometry and strip limits
  localparam int unsigned MATRIX_COLS  = 12;
  localparam int unsigned MATRIX_ROWS  = 10;
  localparam int unsigned MATRIX_START = 12;
  localparam int unsigned TRAIL_LEN    = 3;
  localparam int unsigned MAX_LEDS     = 256;

  // Register reset values
  localparam int unsigned NUM_LEDS_RST   = 132;
  localparam int unsigned BRIGHT_RST     = 255;

  // Wheel and fade constants
  localparam int unsigned WHEEL_SPAN  = 1536;
  localparam int unsigned PHASE_MUL   = 13;
  localparam int unsigned CORNER_MUL  = 29;
  localparam int unsigned FADE_STEP   = 70;

  // Field and datapath widths
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned PHASE_W  = 6;
  localparam int unsigned CORNER_W = 2;
  localparam int unsigned LEDS_W   = 9;    // strip length register and clamped divisor
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;
  localparam int unsigned VAL_W    = 11;   // idx + phase*13 + corner*29 <= 1161
  localparam int unsigned QUO_W    = 11;   // quotients stay below 2048
  localparam int unsigned REM_W    = 20;   // r * 1536 < 2^20
  localparam int unsigned ROW_W    = 7;    // rel / cols with rel < 256
  localparam int unsigned COORD_W  = 7;    // x, y, dist arithmetic

  // Reciprocal for rel / MATRIX_COLS, exact for rel < 256
  localparam int unsigned RECIP_SH = 16;
  localparam int unsigned RECIP_W  = 17;
  localparam int unsigned COL_RECIP = ((1 << RECIP_SH) + MATRIX_COLS - 1) / MATRIX_COLS;

  localparam int unsigned N_STAGES = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_LEDS   = 2'd0,
    CFG_BRIGHTNESS = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_SPLASH  = 1'b0,
    OP_RAINBOW = 1'b1
  } op_e;

  typedef enum logic [CORNER_W-1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  // Wheel sections (each 256 steps wide)
  typedef enum logic [2:0] {
    SECT_RED_UP   = 3'd0,
    SECT_RED_DN   = 3'd1,
    SECT_BLUE_UP  = 3'd2,
    SECT_GREEN_DN = 3'd3,
    SECT_RED_UP2  = 3'd4,
    SECT_BLUE_DN  = 3'd5
  } sect_e;

  // Sideband that rides along the divider stages
  typedef struct packed {
    logic                 written;
    logic [COLOR_W-1:0]   fade;
  } lrwp_side_t;

  // (v * (s + 1)) >> 8
  function automatic logic [COLOR_W-1:0] scale8(input logic [COLOR_W-1:0] v,
                                                input logic [COLOR_W-1:0] s);
    logic [16:0] prod;
    prod = 17'(v) * (17'(s) + 17'd1);
    return prod[15:8];
  endfunction

  // 255 - 70 * delta, delta within the trail
  function automatic logic [COLOR_W-1:0] fade_of(input logic [1:0] delta);
    logic [9:0] f;
    f = 10'd255 - 10'(delta) * 10'(FADE_STEP);
    return f[COLOR_W-1:0];
  endfunction

endpackage

// ----- rtl/lrwp_front.sv -----
// Front end: index sum for the wheel and serpentine matrix decode (two stages).
// Depends on lrwp_pkg.
`timescale 1ns / 1ps
module lrwp_front (
  input  logic                          clk_i,
  input  logic                          en_a_i,
  input  logic                          en_b_i,
  input  logic [lrwp_pkg::LEDS_W-1:0]   n_i,
  input  logic                          operation_i,
  input  logic [lrwp_pkg::IDX_W-1:0]    led_index_i,
  input  logic [lrwp_pkg::PHASE_W-1:0]  phase_i,
  input  logic [lrwp_pkg::CORNER_W-1:0] corner_i,
  input  logic                          pixel_lit_i,
  output logic [lrwp_pkg::VAL_W-1:0]    val_o,
  output lrwp_pkg::lrwp_side_t          side_o
);
  import lrwp_pkg::*;

  localparam int unsigned MatEnd = MATRIX_START + MATRIX_COLS * MATRIX_ROWS;

  // Stage A registers
  logic                  op_q, lit_q, range_q, mat_q;
  logic [PHASE_W-1:0]    phase_q;
  logic [CORNER_W-1:0]   corner_q;
  logic [VAL_W-1:0]      val_q;
  logic [IDX_W-1:0]      rel_q;
  logic [ROW_W-1:0]      row_q;

  logic                  range_d, mat_d;
  logic [VAL_W-1:0]      sum_d, val_d;
  logic [IDX_W-1:0]      rel_d;
  logic [IDX_W+RECIP_W-1:0] rprod;
  logic [ROW_W-1:0]      row_d;

  // Stage A: range checks, wheel index (summed for the wipe), row by reciprocal
  always_comb begin
    range_d = (n_i != '0) && ({1'b0, led_index_i} < n_i);
    mat_d   = (11'(led_index_i) >= 11'(MATRIX_START)) && (11'(led_index_i) < 11'(MatEnd));
    sum_d   = VAL_W'(led_index_i) + VAL_W'(phase_i) * VAL_W'(PHASE_MUL)
            + VAL_W'(corner_i) * VAL_W'(CORNER_MUL);
    val_d   = (op_e'(operation_i) == OP_RAINBOW) ? VAL_W'(led_index_i) : sum_d;
    rel_d   = led_index_i - IDX_W'(MATRIX_START);
    rprod   = (IDX_W+RECIP_W)'(rel_d) * (IDX_W+RECIP_W)'(COL_RECIP);
    row_d   = rprod[RECIP_SH +: ROW_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      op_q     <= operation_i;
      lit_q    <= pixel_lit_i;
      range_q  <= range_d;
      mat_q    <= mat_d;
      phase_q  <= phase_i;
      corner_q <= corner_i;
      val_q    <= val_d;
      rel_q    <= rel_d;
      row_q    <= row_d;
    end
  end

  // Stage B: column, x/y, corner distance, trail test, fade
  logic [COORD_W-1:0] col, x, y, xr, yr, corner_dist, diff;
  logic               hit, written_d;
  logic [COLOR_W-1:0] fade_d;

  always_comb begin
    col  = COORD_W'(COORD_W'(rel_q) - COORD_W'(row_q) * COORD_W'(MATRIX_COLS));
    x    = row_q[0] ? col : COORD_W'(MATRIX_COLS - 1) - col;
    y    = COORD_W'(MATRIX_ROWS - 1) - COORD_W'(row_q);
    xr   = COORD_W'(MATRIX_COLS - 1) - x;
    yr   = COORD_W'(MATRIX_ROWS - 1) - y;
    unique case (corner_e'(corner_q))
      CORNER_TL: corner_dist = x + y;
      CORNER_TR: corner_dist = xr + y;
      CORNER_BR: corner_dist = xr + yr;
      default:   corner_dist = x + yr;
    endcase
    diff = COORD_W'(phase_q) - corner_dist;
    hit  = (COORD_W'(phase_q) >= corner_dist) && (diff <= COORD_W'(TRAIL_LEN));
    if (op_e'(op_q) == OP_RAINBOW) begin
      written_d = range_q && lit_q;
      fade_d    = 8'hFF;
    end else begin
      written_d = range_q && mat_q && hit;
      fade_d    = fade_of(diff[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      val_o          <= val_q;
      side_o.written <= written_d;
      side_o.fade    <= fade_d;
    end
  end

endmodule

// ----- rtl/lrwp_div_stage.sv -----
// One registered slice of a restoring divider: steps StepHi down to StepLo.
// Depends on lrwp_pkg.
`timescale 1ns / 1ps
module lrwp_div_stage #(
  parameter int unsigned StepHi = 10,
  parameter int unsigned StepLo = 6
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lrwp_pkg::LEDS_W-1:0]  div_i,
  input  logic [lrwp_pkg::REM_W-1:0]   rem_i,
  input  logic [lrwp_pkg::QUO_W-1:0]   quot_i,
  input  lrwp_pkg::lrwp_side_t         side_i,
  output logic [lrwp_pkg::REM_W-1:0]   rem_o,
  output logic [lrwp_pkg::QUO_W-1:0]   quot_o,
  output lrwp_pkg::lrwp_side_t         side_o
);
  import lrwp_pkg::*;

  logic [REM_W-1:0] rem, cand;
  logic [QUO_W-1:0] quot;

  // Compare and subtract the shifted divisor, one quotient bit per step
  always_comb begin
    rem  = rem_i;
    quot = quot_i;
    cand = '0;
    for (int i = StepHi; i >= int'(StepLo); i--) begin
      cand = REM_W'(div_i) << i;
      if (rem >= cand) begin
        rem  = rem - cand;
        quot = quot | (QUO_W'(1) << i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem;
      quot_o <= quot;
      side_o <= side_i;
    end
  end

endmodule

// ----- rtl/lrwp_color.sv -----
// Wheel color from the quotient, brightness scale, then fade scale (two stages).
// Depends on lrwp_pkg.
`timescale 1ns / 1ps
module lrwp_color (
  input  logic                          clk_i,
  input  logic                          en_wheel_i,
  input  logic                          en_fade_i,
  input  logic [lrwp_pkg::QUO_W-1:0]    wheel_i,
  input  logic [lrwp_pkg::COLOR_W-1:0]  bright_i,
  input  lrwp_pkg::lrwp_side_t          side_i,
  output logic [lrwp_pkg::COLOR_W-1:0]  red_o,
  output logic [lrwp_pkg::COLOR_W-1:0]  green_o,
  output logic [lrwp_pkg::COLOR_W-1:0]  blue_o,
  output logic                          written_o
);
  import lrwp_pkg::*;

  logic [COLOR_W-1:0] r, g, b, off;
  logic [COLOR_W-1:0] r_q, g_q, b_q;
  lrwp_side_t         side_q;

  // Six-section wheel
  always_comb begin
    off = wheel_i[7:0];
    r = '0;
    g = '0;
    b = '0;
    unique case (sect_e'(wheel_i[10:8]))
      SECT_RED_UP:   begin r = 8'hFF;       g = off;          end
      SECT_RED_DN:   begin r = 8'hFF - off; g = 8'hFF;        end
      SECT_BLUE_UP:  begin g = 8'hFF;       b = off;          end
      SECT_GREEN_DN: begin g = 8'hFF - off; b = 8'hFF;        end
      SECT_RED_UP2:  begin r = off;         b = 8'hFF;        end
      default:       begin r = 8'hFF;       b = 8'hFF - off;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_wheel_i) begin
      r_q    <= scale8(r, bright_i);
      g_q    <= scale8(g, bright_i);
      b_q    <= scale8(b, bright_i);
      side_q <= side_i;
    end
  end

  // Fade and blank unwritten pixels
  always_ff @(posedge clk_i) begin
    if (en_fade_i) begin
      red_o     <= side_q.written ? scale8(r_q, side_q.fade) : '0;
      green_o   <= side_q.written ? scale8(g_q, side_q.fade) : '0;
      blue_o    <= side_q.written ? scale8(b_q, side_q.fade) : '0;
      written_o <= side_q.written;
    end
  end

endmodule

// ----- rtl/led_matrix_rainbow_wipe_pixel.sv -----
// Top level of the rainbow wipe pixel pipeline: handshake, config registers, stages.
// Depends on lrwp_pkg, lrwp_front, lrwp_div_stage, lrwp_color.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o | operation, led_index, phase, corner,
//           |           |                         | pixel_lit
//   out     | output    | out_valid_o/out_stall_i | red, green, blue, pixel_written
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Eight register stages: two front (matrix decode), four divider slices (mod strip length,
// then the 1536-step wheel quotient), two color (brightness, fade). One pixel per cycle
// sustained while out_stall_i is low.
// Each stage moves on when it is empty or the stage after it moves, so bubbles collapse
// and a stalled output holds only what is behind it.
// Reset clears the valid bits and loads a strip length of 132 and brightness 255;
// cfg is always ready.
`timescale 1ns / 1ps
module led_matrix_rainbow_wipe_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [lrwp_pkg::IDX_W-1:0]      led_index_i,
  input  logic [lrwp_pkg::PHASE_W-1:0]    phase_i,
  input  logic [lrwp_pkg::CORNER_W-1:0]   corner_i,
  input  logic                            pixel_lit_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lrwp_pkg::COLOR_W-1:0]    red_o,
  output logic [lrwp_pkg::COLOR_W-1:0]    green_o,
  output logic [lrwp_pkg::COLOR_W-1:0]    blue_o,
  output logic                            pixel_written_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrwp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrwp_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import lrwp_pkg::*;

  localparam int unsigned LedsRst = (NUM_LEDS_RST > MAX_LEDS) ? MAX_LEDS : NUM_LEDS_RST;

  // Config registers; the strip length is stored already clamped to MAX_LEDS
  logic [LEDS_W-1:0]  n_q, n_d;
  logic [COLOR_W-1:0] bright_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (32'(cfg_data_i) > MAX_LEDS) n_d = LEDS_W'(MAX_LEDS);
    else                           n_d = cfg_data_i[LEDS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= LEDS_W'(LedsRst);
      bright_q <= COLOR_W'(BRIGHT_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_LEDS:   n_q      <= n_d;
        CFG_BRIGHTNESS: bright_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance chain
  logic [N_STAGES-1:0] v_q, v_d, adv;

  always_comb begin
    adv[N_STAGES-1] = !v_q[N_STAGES-1] || !out_stall_i;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d = v_q;
    if (adv[0]) v_d[0] = in_valid_i;
    for (int k = 1; k < N_STAGES; k++) begin
      if (adv[k]) v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[N_STAGES-1];

  // Datapath
  logic [VAL_W-1:0]   val;
  lrwp_side_t         side_f, side_m0, side_m1, side_q0, side_q1;
  logic [REM_W-1:0]   rem_m0, rem_m1, rem_q0, rem_q1, num;
  logic [QUO_W-1:0]   quo_q0, quo_q1;

  lrwp_front u_front (
    .clk_i       (clk_i),
    .en_a_i      (adv[0]),
    .en_b_i      (adv[1]),
    .n_i         (n_q),
    .operation_i (operation_i),
    .led_index_i (led_index_i),
    .phase_i     (phase_i),
    .corner_i    (corner_i),
    .pixel_lit_i (pixel_lit_i),
    .val_o       (val),
    .side_o      (side_f)
  );

  // index mod strip length
  lrwp_div_stage #(.StepHi(10), .StepLo(6)) u_mod_hi (
    .clk_i (clk_i), .en_i (adv[2]), .div_i (n_q),
    .rem_i (REM_W'(val)), .quot_i ('0), .side_i (side_f),
    .rem_o (rem_m0), .quot_o (), .side_o (side_m0)
  );

  lrwp_div_stage #(.StepHi(5), .StepLo(0)) u_mod_lo (
    .clk_i (clk_i), .en_i (adv[3]), .div_i (n_q),
    .rem_i (rem_m0), .quot_i ('0), .side_i (side_m0),
    .rem_o (rem_m1), .quot_o (), .side_o (side_m1)
  );

  // (r * 1536) / strip length, r below the strip length
  assign num = (REM_W'(rem_m1[LEDS_W-1:0]) << 10) + (REM_W'(rem_m1[LEDS_W-1:0]) << 9);

  lrwp_div_stage #(.StepHi(10), .StepLo(5)) u_quo_hi (
    .clk_i (clk_i), .en_i (adv[4]), .div_i (n_q),
    .rem_i (num), .quot_i ('0), .side_i (side_m1),
    .rem_o (rem_q0), .quot_o (quo_q0), .side_o (side_q0)
  );

  lrwp_div_stage #(.StepHi(4), .StepLo(0)) u_quo_lo (
    .clk_i (clk_i), .en_i (adv[5]), .div_i (n_q),
    .rem_i (rem_q0), .quot_i (quo_q0), .side_i (side_q0),
    .rem_o (rem_q1), .quot_o (quo_q1), .side_o (side_q1)
  );

  lrwp_color u_color (
    .clk_i      (clk_i),
    .en_wheel_i (adv[6]),
    .en_fade_i  (adv[7]),
    .wheel_i    (quo_q1),
    .bright_i   (bright_q),
    .side_i     (side_q1),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .written_o  (pixel_written_o)
  );

  // Checks
  logic in_xfer, out_xfer, rem_tail_ok;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign rem_tail_ok = (rem_q1 < REM_W'(n_q)) || (n_q == '0);

  a_black_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_written_o |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("unwritten pixel carries color");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && v_q == '1)
    else $error("input stalled while the pipeline has room");

  a_occupancy_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_xfer |=> $countones(v_q) == $past($countones(v_q)) + 1)
    else $error("accepted pixel lost in pipeline");

  a_occupancy_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer && out_xfer |=> $countones(v_q) + 1 == $past($countones(v_q)))
    else $error("pixel duplicated in pipeline");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> rem_tail_ok)
    else $error("wheel divider remainder not below divisor");

  a_clamped_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_LEDS)
    else $error("strip length above limit");

endmodule

// ----- bench/lrwp_checker.sv -----
// Scoreboard for the rainbow wipe pixel pipeline: predicts each pixel color and checks it.
// Depends on lrwp_pkg; instantiated by tb_top beside the block and fed its channel signals.
`timescale 1ns / 1ps
module lrwp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel input channel
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           operation_i,
  input  logic [lrwp_pkg::IDX_W-1:0]     led_index_i,
  input  logic [lrwp_pkg::PHASE_W-1:0]   phase_i,
  input  logic [lrwp_pkg::CORNER_W-1:0]  corner_i,
  input  logic                           pixel_lit_i,
  // color output channel
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [lrwp_pkg::COLOR_W-1:0]   red_i,
  input  logic [lrwp_pkg::COLOR_W-1:0]   green_i,
  input  logic [lrwp_pkg::COLOR_W-1:0]   blue_i,
  input  logic                           pixel_written_i,
  // register writes
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [lrwp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lrwp_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // status toward the top
  output int unsigned                    pending_o,
  output int unsigned                    lit_count_o,
  output int unsigned                    fail_count_o
);
  import lrwp_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t rgb;
    logic written;
  } pixel_color_t;

  // shadow copy of the register file
  logic [LEDS_W-1:0]  strip_len;
  logic [COLOR_W-1:0] bright;

  pixel_color_t expected_colors[$];

  // (v * (s + 1)) >> 8
  function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] v,
                                             input logic [COLOR_W-1:0] s);
    logic [15:0] prod;
    prod = {8'd0, v} * ({8'd0, s} + 16'd1);
    return prod[15:8];
  endfunction

  // six-section color wheel over n positions, then global brightness
  function automatic rgb_t wheel_rgb(input int unsigned pos, input int unsigned n);
    int unsigned        w;
    logic [COLOR_W-1:0] off;
    rgb_t               c;
    w   = ((pos % n) * WHEEL_SPAN) / n;
    off = 8'(w % 256);
    c   = '0;
    case (sect_e'(w / 256))
      SECT_RED_UP: begin
        c.r = 8'd255;
        c.g = off;
      end
      SECT_RED_DN: begin
        c.r = 8'd255 - off;
        c.g = 8'd255;
      end
      SECT_BLUE_UP: begin
        c.g = 8'd255;
        c.b = off;
      end
      SECT_GREEN_DN: begin
        c.g = 8'd255 - off;
        c.b = 8'd255;
      end
      SECT_RED_UP2: begin
        c.r = off;
        c.b = 8'd255;
      end
      default: begin
        c.r = 8'd255;
        c.b = 8'd255 - off;
      end
    endcase
    c.r = dim(c.r, bright);
    c.g = dim(c.g, bright);
    c.b = dim(c.b, bright);
    return c;
  endfunction

  // color of one pixel under the current register settings
  function automatic pixel_color_t pixel_color(input op_e op, input logic [IDX_W-1:0] li,
                                               input logic [PHASE_W-1:0] ph,
                                               input corner_e cn, input logic lit);
    int unsigned        n, idx, phase, rel, row, col, x, y, xr, yr, steps, delta;
    logic [COLOR_W-1:0] fade;
    rgb_t               c;
    pixel_color_t       res;
    res   = '0;
    n     = (strip_len > MAX_LEDS) ? MAX_LEDS : strip_len;
    idx   = li;
    phase = ph;
    if (n != 0 && idx < n) begin
      if (op == OP_RAINBOW) begin
        if (lit) begin
          res.rgb     = wheel_rgb(idx, n);
          res.written = 1'b1;
        end
      end else if (idx >= MATRIX_START && idx < MATRIX_START + MATRIX_COLS * MATRIX_ROWS) begin
        // serpentine: bottom row first, running right to left
        rel = idx - MATRIX_START;
        row = rel / MATRIX_COLS;
        col = rel % MATRIX_COLS;
        x   = (row % 2 == 0) ? MATRIX_COLS - 1 - col : col;
        y   = MATRIX_ROWS - 1 - row;
        xr  = MATRIX_COLS - 1 - x;
        yr  = MATRIX_ROWS - 1 - y;
        case (cn)
          CORNER_TL: steps = x + y;
          CORNER_TR: steps = xr + y;
          CORNER_BR: steps = xr + yr;
          default:   steps = x + yr;
        endcase
        // lit only inside the trail behind the wipe front
        if (phase >= steps && phase - steps <= TRAIL_LEN) begin
          delta       = phase - steps;
          fade        = 8'(255 - delta * FADE_STEP);
          c           = wheel_rgb((idx + phase * PHASE_MUL + 32'(cn) * CORNER_MUL) % n, n);
          res.rgb.r   = dim(c.r, fade);
          res.rgb.g   = dim(c.g, fade);
          res.rgb.b   = dim(c.b, fade);
          res.written = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // watch all three channels; writes must only land while the pipe is empty (not enforced here)
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_color_t want;
    if (!rst_ni) begin
      strip_len = LEDS_W'(NUM_LEDS_RST);
      bright    = COLOR_W'(BRIGHT_RST);
      expected_colors.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_NUM_LEDS:   strip_len = cfg_data_i;
          CFG_BRIGHTNESS: bright    = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_colors.push_back(pixel_color(op_e'(operation_i), led_index_i, phase_i,
                                              corner_e'(corner_i), pixel_lit_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_colors.size() == 0) begin
          $error("color transfer with nothing expected: r=%0d g=%0d b=%0d written=%0b",
                 red_i, green_i, blue_i, pixel_written_i);
          fail_count_o++;
        end else begin
          want = expected_colors.pop_front();
          check_field("red", want.rgb.r, red_i);
          check_field("green", want.rgb.g, green_i);
          check_field("blue", want.rgb.b, blue_i);
          check_field("pixel_written", {7'd0, want.written}, {7'd0, pixel_written_i});
          if (want.written)
            lit_count_o++;
        end
      end
    end
    pending_o = expected_colors.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the rainbow wipe pixel pipeline: clock, reset, stimulus and verdict.
// Depends on lrwp_pkg, led_matrix_rainbow_wipe_pixel and lrwp_checker.
`timescale 1ns / 1ps
module tb_top;
  import lrwp_pkg::*;

  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned ITEMS_PER_SET = 55;

  typedef enum int {
    TRAFFIC_PLAIN,
    TRAFFIC_QUIET,
    TRAFFIC_HOLD,
    TRAFFIC_PAUSE
  } traffic_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  op_e                  operation = OP_SPLASH;
  logic [IDX_W-1:0]     led_index = '0;
  logic [PHASE_W-1:0]   phase = '0;
  corner_e              corner = CORNER_TL;
  logic                 pixel_lit = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COLOR_W-1:0]   red, green, blue;
  logic                 pixel_written;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_e             cfg_index = CFG_NUM_LEDS;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int unsigned pending, lit_count, fail_count;
  int unsigned sent, settings_run, stuck;
  int unsigned hold_left, hold_reqs, hold_done;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_matrix_rainbow_wipe_pixel dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .led_index_i    (led_index),
    .phase_i        (phase),
    .corner_i       (corner),
    .pixel_lit_i    (pixel_lit),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .pixel_written_o(pixel_written),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  lrwp_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .led_index_i    (led_index),
    .phase_i        (phase),
    .corner_i       (corner),
    .pixel_lit_i    (pixel_lit),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .pixel_written_i(pixel_written),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .lit_count_o    (lit_count),
    .fail_count_o   (fail_count)
  );

  // receiver: random stalls, a quiet stretch, and a long hold-off on request
  initial begin : color_sink
    forever begin
      @(posedge clk);
      if (hold_done != hold_reqs) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(99) < 19);
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d colors outstanding", stuck, pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // offer one pixel, with random idle cycles ahead of it, until it transfers
  task automatic push_pixel(input op_e op, input logic [IDX_W-1:0] idx,
                            input logic [PHASE_W-1:0] ph, input corner_e cn, input logic lit);
    while (!tx_quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    led_index <= idx;
    phase     <= ph;
    corner    <= cn;
    pixel_lit <= lit;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent++;
  endtask

  // random pixel, mostly inside the strip and, for the wipe, inside the matrix near the front
  task automatic push_random_pixel(input int unsigned n_eff);
    op_e         op;
    int unsigned idx, ph, hi;
    op = op_e'($urandom_range(1));
    if (n_eff != 0 && $urandom_range(99) < 75)
      idx = $urandom_range(n_eff - 1);
    else
      idx = $urandom_range(255);
    hi = (n_eff < MATRIX_START + MATRIX_COLS * MATRIX_ROWS) ? n_eff :
         MATRIX_START + MATRIX_COLS * MATRIX_ROWS;
    if (op == OP_SPLASH && hi > MATRIX_START && $urandom_range(99) < 70)
      idx = $urandom_range(hi - 1, MATRIX_START);
    ph = ($urandom_range(99) < 70) ? $urandom_range(23) : $urandom_range(63);
    push_pixel(op, 8'(idx), 6'(ph), corner_e'($urandom_range(3)), $urandom_range(99) < 80);
  endtask

  // stop offering and wait for every outstanding color
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DAT_W-1:0] len, input logic [CFG_DAT_W-1:0] br);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_LEDS;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_index <= CFG_BRIGHTNESS;
    cfg_data  <= br;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one register setting followed by a burst of random pixels
  task automatic run_setting(input logic [CFG_DAT_W-1:0] len, input logic [CFG_DAT_W-1:0] br,
                             input traffic_e traffic);
    int unsigned n_eff;
    drain();
    program_regs(len, br);
    n_eff = (len > MAX_LEDS) ? MAX_LEDS : len;
    settings_run++;
    tx_quiet = (traffic == TRAFFIC_QUIET);
    rx_quiet = (traffic == TRAFFIC_QUIET);
    for (int unsigned k = 0; k < ITEMS_PER_SET; k++) begin
      if (traffic == TRAFFIC_HOLD && k == 8)
        hold_reqs++;
      if (traffic == TRAFFIC_PAUSE && k == ITEMS_PER_SET / 2)
        drain();
      push_random_pixel(n_eff);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels under the reset settings (132 LEDs, full brightness)
    settings_run = 1;
    push_pixel(OP_SPLASH, 8'd0, 6'd0, CORNER_TL, 1'b0);     // ahead of the matrix
    push_pixel(OP_SPLASH, 8'd11, 6'd63, CORNER_TR, 1'b1);   // last index before it
    push_pixel(OP_SPLASH, 8'd12, 6'd20, CORNER_TL, 1'b1);   // on the front
    push_pixel(OP_SPLASH, 8'd12, 6'd21, CORNER_TL, 1'b0);   // trail, one behind
    push_pixel(OP_SPLASH, 8'd12, 6'd22, CORNER_TL, 1'b1);
    push_pixel(OP_SPLASH, 8'd12, 6'd23, CORNER_TL, 1'b1);   // end of trail
    push_pixel(OP_SPLASH, 8'd12, 6'd24, CORNER_TL, 1'b1);   // front has passed
    push_pixel(OP_SPLASH, 8'd12, 6'd19, CORNER_TL, 1'b1);   // front not there yet
    push_pixel(OP_SPLASH, 8'd131, 6'd0, CORNER_TR, 1'b1);   // corner pixel, distance 0
    push_pixel(OP_SPLASH, 8'd131, 6'd9, CORNER_BR, 1'b1);
    push_pixel(OP_SPLASH, 8'd131, 6'd20, CORNER_BL, 1'b1);
    push_pixel(OP_SPLASH, 8'd132, 6'd63, CORNER_BR, 1'b1);  // past the matrix and strip
    push_pixel(OP_SPLASH, 8'd255, 6'd63, CORNER_BL, 1'b1);
    push_pixel(OP_SPLASH, 8'd71, 6'd63, CORNER_BR, 1'b1);   // far outside the trail
    push_pixel(OP_SPLASH, 8'd30, 6'd10, CORNER_BR, 1'b0);
    push_pixel(OP_RAINBOW, 8'd0, 6'd0, CORNER_TL, 1'b1);    // wheel start
    push_pixel(OP_RAINBOW, 8'd131, 6'd63, CORNER_BR, 1'b1); // last LED
    push_pixel(OP_RAINBOW, 8'd66, 6'd5, CORNER_TR, 1'b0);   // unlit pixel
    push_pixel(OP_RAINBOW, 8'd132, 6'd0, CORNER_TL, 1'b1);  // beyond the strip
    push_pixel(OP_RAINBOW, 8'd255, 6'd63, CORNER_BL, 1'b1);
    push_pixel(OP_RAINBOW, 8'd22, 6'd0, CORNER_TL, 1'b1);   // exact section boundary
    push_pixel(OP_RAINBOW, 8'd110, 6'd33, CORNER_TR, 1'b1); // last section
    for (int unsigned k = 0; k < ITEMS_PER_SET; k++)
      push_random_pixel(NUM_LEDS_RST);

    run_setting(9'd256, 9'd255, TRAFFIC_QUIET);   // full-size strip
    run_setting(9'd1, 9'd0, TRAFFIC_PLAIN);       // single LED, brightness off
    run_setting(9'd0, 9'd128, TRAFFIC_PLAIN);     // empty strip
    run_setting(9'd511, 9'h1C8, TRAFFIC_HOLD);    // oversized length, stray data bit
    run_setting(9'd132, 9'd1, TRAFFIC_PAUSE);
    run_setting(9'd100, 9'd77, TRAFFIC_PLAIN);    // strip ends inside the matrix
    run_setting(9'd257, 9'd255, TRAFFIC_PLAIN);
    run_setting(9'd12, 9'd128, TRAFFIC_PLAIN);    // strip ends before the matrix
    run_setting(9'($urandom_range(511)), 9'($urandom_range(511)), TRAFFIC_PLAIN);
    run_setting(9'($urandom_range(511)), 9'($urandom_range(511)), TRAFFIC_HOLD);

    drain();
    repeat (2 * N_STAGES) @(posedge clk);
    $display("Sent %0d pixels over %0d register settings; %0d came back with a color.",
             sent, settings_run, lit_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
